// File: sv/rwbc_pkg.sv
// ----------------------------------------------------------------------------
// rwbc_pkg
// shared types and constants of the register window bytecode core
// ----------------------------------------------------------------------------
`default_nettype none

package rwbc_pkg;

  // data path and storage geometry
  localparam int unsigned DW          = 64;
  localparam int unsigned RF_AW       = 16;
  localparam int unsigned RF_DEPTH    = 1 << RF_AW;
  localparam int unsigned ST_AW       = 12;
  localparam int unsigned ST_DEPTH    = 1 << ST_AW;
  localparam int unsigned SD_W        = ST_AW + 1;
  localparam int unsigned IDX_W       = 24;
  localparam int unsigned REG_W       = 16;
  localparam int unsigned FS_W        = 16;
  localparam int unsigned ST_W        = IDX_W + REG_W + FS_W;
  localparam int unsigned DCNT_W      = $clog2(DW) + 1;
  localparam int unsigned HW          = DW / 2;
  localparam logic [FS_W-1:0] MAIN_SIZE_RST = 16'd256;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 40;

  // opcodes
  localparam logic [4:0] OP_EXIT    = 5'd0;
  localparam logic [4:0] OP_MOVE    = 5'd1;
  localparam logic [4:0] OP_LOADIMM = 5'd2;
  localparam logic [4:0] OP_JUMP    = 5'd3;
  localparam logic [4:0] OP_FUNC    = 5'd4;
  localparam logic [4:0] OP_BB      = 5'd5;
  localparam logic [4:0] OP_ADD     = 5'd6;
  localparam logic [4:0] OP_SUB     = 5'd7;
  localparam logic [4:0] OP_MUL     = 5'd8;
  localparam logic [4:0] OP_DIV     = 5'd9;
  localparam logic [4:0] OP_MOD     = 5'd10;
  localparam logic [4:0] OP_POW     = 5'd11;
  localparam logic [4:0] OP_ADDI    = 5'd12;
  localparam logic [4:0] OP_SUBI    = 5'd13;
  localparam logic [4:0] OP_MULI    = 5'd14;
  localparam logic [4:0] OP_DIVI    = 5'd15;
  localparam logic [4:0] OP_MODI    = 5'd16;
  localparam logic [4:0] OP_BEQ     = 5'd17;
  localparam logic [4:0] OP_BLT     = 5'd18;
  localparam logic [4:0] OP_BEQI    = 5'd19;
  localparam logic [4:0] OP_BLTI    = 5'd20;
  localparam logic [4:0] OP_BLTEI   = 5'd21;
  localparam logic [4:0] OP_CALL    = 5'd22;
  localparam logic [4:0] OP_RETURN  = 5'd23;
  localparam logic [4:0] OP_PUTCHAR = 5'd24;

  // fault codes
  localparam logic [1:0] FLT_NONE   = 2'd0;
  localparam logic [1:0] FLT_DIV0   = 2'd1;
  localparam logic [1:0] FLT_STACK  = 2'd2;
  localparam logic [1:0] FLT_WINDOW = 2'd3;

  // instruction classes assigned by the front end
  typedef enum logic [3:0] {
    CL_EXIT, CL_MOVE, CL_LDI, CL_JUMP, CL_BB, CL_ALU, CL_MDU,
    CL_BR, CL_CALL, CL_RET, CL_PUTC, CL_NOP
  } cls_e;

  // multiply / divide unit operations
  typedef enum logic [1:0] {
    MDU_MUL, MDU_DIV, MDU_MOD, MDU_POW
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] result;
  } mdu_rsp_t;

  // one queued instruction
  typedef struct packed {
    logic [4:0]       op;
    logic [REG_W-1:0] dst;
    logic [REG_W-1:0] sa;
    logic [REG_W-1:0] sb;
    logic [REG_W-1:0] sc;
    logic [63:0]      imm;
    logic [IDX_W-1:0] tf;
    logic [IDX_W-1:0] tt;
    logic [IDX_W-1:0] fol;
    logic [1:0]       argc;
    logic [FS_W-1:0]  csize;
    cls_e             cls;
  } item_t;

endpackage

`default_nettype wire

// File: sv/rwbc_mdu.sv
// ----------------------------------------------------------------------------
// rwbc_mdu
// iterative multiply, signed divide / modulo and power unit
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_mdu (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rwbc_pkg::mdu_req_t     req_i,
  input  wire logic [rwbc_pkg::DW-1:0] a_i,
  input  wire logic [rwbc_pkg::DW-1:0] b_i,
  output rwbc_pkg::mdu_rsp_t          rsp_o
);
  import rwbc_pkg::*;

  localparam logic [2:0] U_IDLE   = 3'd0;
  localparam logic [2:0] U_MUL    = 3'd1;
  localparam logic [2:0] U_DIV    = 3'd2;
  localparam logic [2:0] U_POWCHK = 3'd3;
  localparam logic [2:0] U_POWA   = 3'd4;
  localparam logic [2:0] U_POWB   = 3'd5;

  logic [2:0]        ust_q;
  logic [DW-1:0]     mx_q, my_q, prod_q, macc_q;
  logic [1:0]        mstep_q;
  logic              mbusy_q, mfin_q;
  logic [DW-1:0]     pacc_q, pbase_q, pexp_q;
  logic [DW-1:0]     rem_q, quot_q, dvs_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              neg_q, want_mod_q;
  logic              done_q;
  logic [DW-1:0]     res_q;

  logic [HW-1:0]     mul_x, mul_y;
  logic [DW-1:0]     mul_p;
  logic [DW:0]       rem_sh, rem_sub;
  logic [DW-1:0]     abs_a, abs_b;

  // one half-width multiplier, shared over the partial products
  always_comb begin
    case (mstep_q)
      2'd0:    begin mul_x = mx_q[HW-1:0];  mul_y = my_q[HW-1:0];  end
      2'd1:    begin mul_x = mx_q[HW-1:0];  mul_y = my_q[DW-1:HW]; end
      2'd2:    begin mul_x = mx_q[DW-1:HW]; mul_y = my_q[HW-1:0];  end
      default: begin mul_x = mx_q[HW-1:0];  mul_y = my_q[HW-1:0];  end
    endcase
    mul_p = DW'(mul_x) * DW'(mul_y);
  end

  // restoring division step and operand magnitudes
  always_comb begin
    rem_sh  = {rem_q, quot_q[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    abs_a   = a_i[DW-1] ? DW'(0) - a_i : a_i;
    abs_b   = b_i[DW-1] ? DW'(0) - b_i : b_i;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q   <= U_IDLE;
      mbusy_q <= 1'b0;
      mfin_q  <= 1'b0;
      mstep_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      mfin_q <= 1'b0;

      // multiply engine: three partial products, added into the accumulator in turn
      if (mbusy_q) begin
        mstep_q <= mstep_q + 2'd1;
        case (mstep_q)
          2'd0: prod_q <= mul_p;
          2'd1: begin
            macc_q <= prod_q;
            prod_q <= mul_p;
          end
          2'd2: begin
            macc_q <= macc_q + {prod_q[HW-1:0], {HW{1'b0}}};
            prod_q <= mul_p;
          end
          default: begin
            macc_q  <= macc_q + {prod_q[HW-1:0], {HW{1'b0}}};
            mbusy_q <= 1'b0;
            mfin_q  <= 1'b1;
          end
        endcase
      end

      case (ust_q)
        U_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              MDU_MUL: begin
                mx_q <= a_i; my_q <= b_i;
                mbusy_q <= 1'b1; mstep_q <= 2'd0;
                ust_q <= U_MUL;
              end
              MDU_POW: begin
                pacc_q  <= DW'(1);
                pbase_q <= a_i;
                pexp_q  <= b_i;
                ust_q   <= U_POWCHK;
              end
              default: begin
                rem_q      <= '0;
                quot_q     <= abs_a;
                dvs_q      <= abs_b;
                dcnt_q     <= '0;
                want_mod_q <= (req_i.op == MDU_MOD);
                neg_q      <= (req_i.op == MDU_MOD) ? a_i[DW-1] : (a_i[DW-1] ^ b_i[DW-1]);
                ust_q      <= U_DIV;
              end
            endcase
          end
        end
        U_MUL: begin
          if (mfin_q) begin
            res_q  <= macc_q;
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        U_DIV: begin
          if (dcnt_q == DCNT_W'(DW)) begin
            if (want_mod_q) res_q <= neg_q ? DW'(0) - rem_q : rem_q;
            else            res_q <= neg_q ? DW'(0) - quot_q : quot_q;
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end else begin
            dcnt_q <= dcnt_q + DCNT_W'(1);
            if (!rem_sub[DW]) begin
              rem_q  <= rem_sub[DW-1:0];
              quot_q <= {quot_q[DW-2:0], 1'b1};
            end else begin
              rem_q  <= rem_sh[DW-1:0];
              quot_q <= {quot_q[DW-2:0], 1'b0};
            end
          end
        end
        U_POWCHK: begin
          if (pexp_q == '0) begin
            res_q  <= pacc_q;
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end else if (pexp_q[0]) begin
            mx_q <= pacc_q; my_q <= pbase_q;
            mbusy_q <= 1'b1; mstep_q <= 2'd0;
            ust_q <= U_POWA;
          end else begin
            mx_q <= pbase_q; my_q <= pbase_q;
            mbusy_q <= 1'b1; mstep_q <= 2'd0;
            ust_q <= U_POWB;
          end
        end
        U_POWA: begin
          if (mfin_q) begin
            pacc_q <= macc_q;
            mx_q <= pbase_q; my_q <= pbase_q;
            mbusy_q <= 1'b1; mstep_q <= 2'd0;
            ust_q <= U_POWB;
          end
        end
        U_POWB: begin
          if (mfin_q) begin
            pbase_q <= macc_q;
            pexp_q  <= {1'b0, pexp_q[DW-1:1]};
            ust_q   <= U_POWCHK;
          end
        end
        default: ust_q <= U_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/rwbc_front.sv
// ----------------------------------------------------------------------------
// rwbc_front
// accepts instruction transfers, classifies them and queues them
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rwbc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [4:0]                     s_axis_tuser,
  input  wire logic                           pop_i,
  output logic                                head_valid_o,
  output rwbc_pkg::item_t                     head_o
);
  import rwbc_pkg::*;

  item_t      q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  item_t      in_item;
  logic       push, pop;

  function automatic cls_e classify(input logic [4:0] op);
    cls_e c;
    begin
      case (op) inside
        OP_EXIT:                                   c = CL_EXIT;
        OP_MOVE:                                   c = CL_MOVE;
        OP_LOADIMM:                                c = CL_LDI;
        OP_JUMP, OP_FUNC:                          c = CL_JUMP;
        OP_BB:                                     c = CL_BB;
        OP_ADD, OP_SUB, OP_ADDI, OP_SUBI:          c = CL_ALU;
        OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_MULI,
        OP_DIVI, OP_MODI:                          c = CL_MDU;
        [OP_BEQ:OP_BLTEI]:                         c = CL_BR;
        OP_CALL:                                   c = CL_CALL;
        OP_RETURN:                                 c = CL_RET;
        OP_PUTCHAR:                                c = CL_PUTC;
        default:                                   c = CL_NOP;
      endcase
      return c;
    end
  endfunction

  // unpack the transfer
  always_comb begin
    in_item.op    = s_axis_tuser;
    in_item.dst   = s_axis_tdata[15:0];
    in_item.sa    = s_axis_tdata[31:16];
    in_item.sb    = s_axis_tdata[47:32];
    in_item.sc    = s_axis_tdata[63:48];
    in_item.imm   = s_axis_tdata[127:64];
    in_item.tf    = s_axis_tdata[151:128];
    in_item.tt    = s_axis_tdata[175:152];
    in_item.fol   = s_axis_tdata[199:176];
    in_item.argc  = s_axis_tdata[201:200];
    in_item.csize = s_axis_tdata[217:202];
    in_item.cls   = classify(s_axis_tuser);
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid_o  = (cnt_q != 2'd0);
  assign pop           = pop_i && head_valid_o;
  assign head_o        = q_q[rd_ptr_q];

  // two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/rwbc_back.sv
// ----------------------------------------------------------------------------
// rwbc_back
// execution sequencer: register window store, frame stack and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            item_valid_i,
  input  wire rwbc_pkg::item_t                 item_i,
  output logic                                 pop_o,
  input  wire logic                            cfg_valid_i,
  input  wire logic [rwbc_pkg::FS_W-1:0]       cfg_data_i,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rwbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser
);
  import rwbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_RC   = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_ARG  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // storage
  logic [DW-1:0]   rf_mem [RF_DEPTH];
  logic [ST_W-1:0] st_mem [ST_DEPTH];
  logic [DW-1:0]   rf_rdata_q;
  logic [ST_W-1:0] st_rdata_q;

  // architectural state
  logic [2:0]       state_q;
  item_t            it_q;
  logic [DW-1:0]    a_q, b_q, c_q;
  logic [RF_AW-1:0] base_q;
  logic [FS_W-1:0]  cur_size_q;
  logic [SD_W-1:0]  depth_q;
  logic             halt_q;
  logic [1:0]       argk_q;

  // pending result and output register
  logic [IDX_W-1:0] res_next_q;
  logic             res_chv_q;
  logic [7:0]       res_ch_q;
  logic             res_halt_q;
  logic [1:0]       res_flt_q;
  logic             out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic             out_chv_q;

  // combinational
  logic [RF_AW-1:0] rf_raddr, rf_waddr;
  logic             rf_we;
  logic [DW-1:0]    rf_wdata;
  logic [ST_AW-1:0] st_raddr;
  logic             st_we;
  logic [DW-1:0]    b_op;
  logic             use_imm, div_zero;
  logic [IDX_W-1:0] ex_next;
  logic [1:0]       ex_flt;
  logic             ex_chv;
  logic [7:0]       ex_ch;
  logic [DW-1:0]    ex_wdata;
  logic             ex_wr;
  logic             cond;
  logic [RF_AW:0]   new_base;
  logic [RF_AW+1:0] new_top;
  logic             call_ok, ret_ok;
  logic [IDX_W-1:0] fr_ret;
  logic [REG_W-1:0] fr_out;
  logic [FS_W-1:0]  fr_size;
  logic [RF_AW-1:0] ret_base;
  logic [DW-1:0]    arg_val;
  mdu_req_t         mreq;
  mdu_rsp_t         mrsp;

  rwbc_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (a_q),
    .b_i    (b_op),
    .rsp_o  (mrsp)
  );

  // decode of the current instruction
  always_comb begin
    use_imm  = (it_q.op == OP_ADDI) || (it_q.op == OP_SUBI) || (it_q.op == OP_MULI) ||
               (it_q.op == OP_DIVI) || (it_q.op == OP_MODI);
    b_op     = use_imm ? it_q.imm : b_q;
    div_zero = (b_op == '0) && ((it_q.op == OP_DIV) || (it_q.op == OP_MOD) ||
                                (it_q.op == OP_DIVI) || (it_q.op == OP_MODI));
    new_base = {1'b0, base_q} + (RF_AW+1)'(cur_size_q);
    new_top  = {1'b0, new_base} + (RF_AW+2)'(it_q.csize);
    {fr_ret, fr_out, fr_size} = st_rdata_q;
    ret_base = (base_q >= fr_size) ? base_q - fr_size : '0;
    call_ok  = (depth_q < SD_W'(ST_DEPTH)) && !new_base[RF_AW] &&
               (new_top <= (RF_AW+2)'(RF_DEPTH));
    ret_ok   = (depth_q != '0);
    case (argk_q)
      2'd0:    arg_val = a_q;
      2'd1:    arg_val = b_q;
      default: arg_val = c_q;
    endcase
  end

  // branch condition
  always_comb begin
    case (it_q.op)
      OP_BEQ:   cond = (a_q == b_q);
      OP_BLT:   cond = ($signed(a_q) < $signed(b_q));
      OP_BEQI:  cond = (a_q == it_q.imm);
      OP_BLTI:  cond = ($signed(a_q) < $signed(it_q.imm));
      OP_BLTEI: cond = ($signed(a_q) <= $signed(it_q.imm));
      default:  cond = 1'b0;
    endcase
  end

  // execute step results
  always_comb begin
    ex_next  = it_q.fol;
    ex_flt   = FLT_NONE;
    ex_chv   = 1'b0;
    ex_ch    = 8'd0;
    ex_wr    = 1'b0;
    ex_wdata = a_q;
    mreq.start = 1'b0;
    case (it_q.op)
      OP_MUL, OP_MULI: mreq.op = MDU_MUL;
      OP_DIV, OP_DIVI: mreq.op = MDU_DIV;
      OP_MOD, OP_MODI: mreq.op = MDU_MOD;
      default:         mreq.op = MDU_POW;
    endcase
    case (it_q.cls)
      CL_EXIT: ex_next = '0;
      CL_MOVE: ex_wr = 1'b1;
      CL_LDI: begin
        ex_wr    = 1'b1;
        ex_wdata = it_q.imm;
      end
      CL_JUMP: ex_next = it_q.tf;
      CL_BB:   ex_next = (a_q != '0) ? it_q.tt : it_q.tf;
      CL_BR:   ex_next = cond ? it_q.tt : it_q.tf;
      CL_ALU: begin
        ex_wr    = 1'b1;
        ex_wdata = ((it_q.op == OP_ADD) || (it_q.op == OP_ADDI)) ? a_q + b_op : a_q - b_op;
      end
      CL_MDU: begin
        if (div_zero) begin
          ex_wr    = 1'b1;
          ex_wdata = '0;
          ex_flt   = FLT_DIV0;
        end else begin
          mreq.start = (state_q == S_EX);
        end
      end
      CL_CALL: begin
        if (depth_q >= SD_W'(ST_DEPTH)) ex_flt = FLT_STACK;
        else if (!call_ok)              ex_flt = FLT_WINDOW;
        else                            ex_next = it_q.tf;
      end
      CL_RET: begin
        if (!ret_ok) begin
          ex_flt = FLT_STACK;
        end else begin
          ex_wr   = 1'b1;
          ex_next = fr_ret;
        end
      end
      CL_PUTC: begin
        ex_chv = 1'b1;
        ex_ch  = a_q[7:0];
      end
      default: ex_next = it_q.fol;
    endcase
  end

  // memory port control
  always_comb begin
    case (state_q)
      S_RA:    rf_raddr = base_q + it_q.sa;
      S_RB:    rf_raddr = base_q + it_q.sb;
      default: rf_raddr = base_q + it_q.sc;
    endcase
    st_raddr = ST_AW'(depth_q - SD_W'(1));
    rf_we    = 1'b0;
    rf_wdata = ex_wdata;
    rf_waddr = base_q + it_q.dst;
    st_we    = 1'b0;
    case (state_q)
      S_EX: begin
        rf_we = ex_wr;
        if (it_q.cls == CL_RET) rf_waddr = ret_base + fr_out;
        st_we = (it_q.cls == CL_CALL) && call_ok;
      end
      S_WAIT: begin
        rf_we    = mrsp.done;
        rf_wdata = mrsp.result;
      end
      S_ARG: begin
        rf_we    = 1'b1;
        rf_wdata = arg_val;
        rf_waddr = base_q + RF_AW'(argk_q) + RF_AW'(1);
      end
      default: rf_we = 1'b0;
    endcase
  end

  // register window store and frame stack
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rf_rdata_q <= rf_mem[rf_raddr];
    if (st_we) begin
      st_mem[depth_q[ST_AW-1:0]] <= {it_q.fol, it_q.dst, cur_size_q};
    end
    st_rdata_q <= st_mem[st_raddr];
  end

  assign pop_o         = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_chv_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      cur_size_q  <= MAIN_SIZE_RST;
      depth_q     <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      argk_q      <= 2'd0;
    end else begin
      // configuration write
      if (cfg_valid_i) begin
        if (depth_q == '0) cur_size_q <= cfg_data_i;
      end

      // output register drains on transfer
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            it_q <= item_i;
            if (halt_q) begin
              res_next_q <= '0;
              res_chv_q  <= 1'b0;
              res_ch_q   <= 8'd0;
              res_halt_q <= 1'b1;
              res_flt_q  <= FLT_NONE;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_RA;
            end
          end
        end
        S_RA: state_q <= S_RB;
        S_RB: begin
          a_q     <= rf_rdata_q;
          state_q <= S_RC;
        end
        S_RC: begin
          b_q     <= rf_rdata_q;
          state_q <= S_EX;
        end
        S_EX: begin
          c_q        <= rf_rdata_q;
          res_next_q <= ex_next;
          res_chv_q  <= ex_chv;
          res_ch_q   <= ex_ch;
          res_flt_q  <= ex_flt;
          res_halt_q <= (it_q.cls == CL_EXIT);
          state_q    <= S_DONE;
          if (it_q.cls == CL_EXIT) halt_q <= 1'b1;
          if (mreq.start) state_q <= S_WAIT;
          if ((it_q.cls == CL_CALL) && call_ok) begin
            depth_q    <= depth_q + SD_W'(1);
            base_q     <= new_base[RF_AW-1:0];
            cur_size_q <= it_q.csize;
            argk_q     <= 2'd0;
            if (it_q.argc != 2'd0) state_q <= S_ARG;
          end
          if ((it_q.cls == CL_RET) && ret_ok) begin
            depth_q    <= depth_q - SD_W'(1);
            base_q     <= ret_base;
            cur_size_q <= fr_size;
          end
        end
        S_WAIT: begin
          if (mrsp.done) state_q <= S_DONE;
        end
        S_ARG: begin
          argk_q <= argk_q + 2'd1;
          if (argk_q + 2'd1 == it_q.argc) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {5'd0, res_flt_q, res_halt_q, res_ch_q, res_next_q};
            out_chv_q   <= res_chv_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/register_window_bytecode_core.sv
// ----------------------------------------------------------------------------
// register_window_bytecode_core
// executes pre-decoded bytecode against a windowed register store
// ----------------------------------------------------------------------------
// One instruction enters per transfer on the s_axis channel (opcode in tuser,
// operands in tdata) and exactly one result leaves per instruction on the
// m_axis channel (next index, character, halt and fault in tdata, the
// character valid flag in tuser). The cfg channel writes the outermost frame
// size; it is always ready, so write it only while no instruction is in flight.
// A two-entry queue sits behind s_axis, so new instructions are accepted
// while the executor works or while a result waits to be taken.
// Each instruction goes through three register reads on the single store
// port, then an execute state and a result state. mul runs three half-width
// partial products over four steps, div and mod produce one quotient bit
// per cycle, pow squares the base once per exponent bit up to the highest
// set bit and multiplies once more per set bit, and a call copies its
// arguments into the new window one after another.
// After reset the window base, frame stack depth and halt flag are clear
// and the frame size is 256; register contents are not cleared. When
// m_axis stalls, the finished result is held and execution stops once the
// next result is ready; the queue then fills and s_axis tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module register_window_bytecode_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // fields: dst_reg, src_a, src_b, src_c, immediate, target_false,
  // target_true, following_index, arg_count, callee_frame_size
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [rwbc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // fields: op
  input  wire logic [4:0]                      s_axis_tuser,
  // fields: next_index, char_out, halted, fault
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rwbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // fields: char_valid
  output logic                                 m_axis_tuser,
  // main_frame_size write
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rwbc_pkg::FS_W-1:0]       cfg_data_i
);
  import rwbc_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  assign cfg_ready_o = 1'b1;

  // instruction intake and queue
  rwbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .head_valid_o  (head_valid),
    .head_o        (head)
  );

  // executor
  rwbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (head_valid),
    .item_i        (head),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the register window bytecode core
// ----------------------------------------------------------------------------
// Instructions are generated together with their expected results by a
// behavioral copy of the core (register store, windows, frame stack, halt).
// Sources are always written before they are read. A queue feeds a clocked
// driver; a clocked monitor checks every result transfer against the oldest
// expected result. Phases vary the frame size register and the idle/stall
// pattern, include a long receiver hold-off and end with exit.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwbc_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  typedef struct {
    logic [4:0]       op;
    logic [REG_W-1:0] dst, sa, sb, sc;
    logic [63:0]      imm;
    logic [IDX_W-1:0] tf, tt, fol;
    logic [1:0]       argc;
    logic [FS_W-1:0]  csize;
  } instr_t;

  typedef struct {
    logic [IDX_W-1:0] next_idx;
    logic             chv;
    logic [7:0]       ch;
    logic             halted;
    logic [1:0]       fault;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [4:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [FS_W-1:0] cfg_data_i = '0;

  register_window_bytecode_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // shadow state of the core
  logic [63:0]      shadow_regs [int];
  logic [IDX_W-1:0] frame_ret [ST_DEPTH];
  logic [REG_W-1:0] frame_out [ST_DEPTH];
  logic [FS_W-1:0]  frame_size [ST_DEPTH];
  logic [15:0]      win_base = '0;
  logic [FS_W-1:0]  cur_size = MAIN_SIZE_RST;
  int               depth = 0;
  bit               is_halted = 1'b0;

  instr_t   pending_instrs [$];
  outcome_t expected_outcomes [$];
  int       mismatches = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  longint   cycles = 0;

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("register_window_bytecode_core regression: fail");
      $finish;
    end
  end

  // instruction driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_instrs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        instr_t it;
        it = pending_instrs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {6'd0, it.csize, it.argc, it.fol, it.tt, it.tf, it.imm,
                          it.sc, it.sb, it.sa, it.dst};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with a counted hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (m_axis_tdata[23:0] !== e.next_idx) begin
          $error("next_index: expected %0h got %0h", e.next_idx, m_axis_tdata[23:0]);
          mismatches++;
        end
        if (m_axis_tuser !== e.chv) begin
          $error("char_valid: expected %0h got %0h", e.chv, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[31:24] !== e.ch) begin
          $error("char_out: expected %0h got %0h", e.ch, m_axis_tdata[31:24]);
          mismatches++;
        end
        if (m_axis_tdata[32] !== e.halted) begin
          $error("halted: expected %0h got %0h", e.halted, m_axis_tdata[32]);
          mismatches++;
        end
        if (m_axis_tdata[34:33] !== e.fault) begin
          $error("fault: expected %0h got %0h", e.fault, m_axis_tdata[34:33]);
          mismatches++;
        end
      end
    end
  end

  function automatic int reg_loc(logic [REG_W-1:0] r);
    logic [15:0] a;
    a = win_base + r;
    return int'(a);
  endfunction

  function automatic logic [63:0] rd(logic [REG_W-1:0] r);
    return shadow_regs.exists(reg_loc(r)) ? shadow_regs[reg_loc(r)] : 64'd0;
  endfunction

  function automatic logic [63:0] sdivmod(logic [63:0] a, logic [63:0] b, bit want_rem);
    logic [63:0] ma, mb, q, rm;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    rm = ma % mb;
    if (want_rem) return a[63] ? -rm : rm;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] raise(logic [63:0] base, logic [63:0] e);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = acc * base;
      e = e >> 1;
      base = base * base;
    end
    return acc;
  endfunction

  // executes one instruction on the shadow state and queues its result
  task automatic execute(input instr_t it);
    outcome_t o;
    logic [63:0] a, b, dv;
    logic [16:0] nb;
    logic [63:0] args [3];
    o = '{next_idx: it.fol, chv: 1'b0, ch: 8'd0, halted: 1'b0, fault: FLT_NONE};
    pending_instrs.push_back(it);
    if (is_halted) begin
      o.next_idx = '0;
      o.halted = 1'b1;
      expected_outcomes.push_back(o);
      return;
    end
    a = rd(it.sa);
    b = rd(it.sb);
    case (it.op)
      OP_EXIT: begin
        is_halted = 1'b1;
        o.next_idx = '0;
      end
      OP_MOVE:    shadow_regs[reg_loc(it.dst)] = a;
      OP_LOADIMM: shadow_regs[reg_loc(it.dst)] = it.imm;
      OP_JUMP, OP_FUNC: o.next_idx = it.tf;
      OP_BB:   o.next_idx = (a != 0) ? it.tt : it.tf;
      OP_ADD:  shadow_regs[reg_loc(it.dst)] = a + b;
      OP_SUB:  shadow_regs[reg_loc(it.dst)] = a - b;
      OP_MUL:  shadow_regs[reg_loc(it.dst)] = a * b;
      OP_DIV, OP_MOD, OP_DIVI, OP_MODI: begin
        dv = (it.op == OP_DIV || it.op == OP_MOD) ? b : it.imm;
        if (dv == 0) begin
          shadow_regs[reg_loc(it.dst)] = 64'd0;
          o.fault = FLT_DIV0;
        end else begin
          shadow_regs[reg_loc(it.dst)] =
            sdivmod(a, dv, it.op == OP_MOD || it.op == OP_MODI);
        end
      end
      OP_POW:  shadow_regs[reg_loc(it.dst)] = raise(a, b);
      OP_ADDI: shadow_regs[reg_loc(it.dst)] = a + it.imm;
      OP_SUBI: shadow_regs[reg_loc(it.dst)] = a - it.imm;
      OP_MULI: shadow_regs[reg_loc(it.dst)] = a * it.imm;
      OP_BEQ:   o.next_idx = (a == b) ? it.tt : it.tf;
      OP_BLT:   o.next_idx = ($signed(a) < $signed(b)) ? it.tt : it.tf;
      OP_BEQI:  o.next_idx = (a == it.imm) ? it.tt : it.tf;
      OP_BLTI:  o.next_idx = ($signed(a) < $signed(it.imm)) ? it.tt : it.tf;
      OP_BLTEI: o.next_idx = ($signed(a) <= $signed(it.imm)) ? it.tt : it.tf;
      OP_CALL: begin
        nb = {1'b0, win_base} + cur_size;
        if (depth >= ST_DEPTH) begin
          o.fault = FLT_STACK;
        end else if (nb >= RF_DEPTH || nb + it.csize > RF_DEPTH) begin
          o.fault = FLT_WINDOW;
        end else begin
          args[0] = a;
          args[1] = b;
          args[2] = rd(it.sc);
          frame_ret[depth]  = it.fol;
          frame_out[depth]  = it.dst;
          frame_size[depth] = cur_size;
          depth++;
          win_base = nb[15:0];
          cur_size = it.csize;
          for (int k = 0; k < it.argc; k++) shadow_regs[reg_loc(REG_W'(k + 1))] = args[k];
          o.next_idx = it.tf;
        end
      end
      OP_RETURN: begin
        if (depth == 0) begin
          o.fault = FLT_STACK;
        end else begin
          depth--;
          win_base = (win_base >= frame_size[depth]) ? win_base - frame_size[depth] : '0;
          cur_size = frame_size[depth];
          shadow_regs[reg_loc(frame_out[depth])] = a;
          o.next_idx = frame_ret[depth];
        end
      end
      OP_PUTCHAR: begin
        o.chv = 1'b1;
        o.ch = a[7:0];
      end
      default: ;
    endcase
    o.halted = is_halted;
    expected_outcomes.push_back(o);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return 64'($signed($urandom_range(40)) - 20);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    return ($urandom_range(9) == 0) ? REG_W'($urandom) : REG_W'($urandom_range(15));
  endfunction

  function automatic instr_t blank(logic [4:0] op);
    instr_t it;
    it.op = op;
    it.dst = pick_reg(); it.sa = pick_reg(); it.sb = pick_reg(); it.sc = pick_reg();
    it.imm = pick_value();
    it.tf = IDX_W'($urandom); it.tt = IDX_W'($urandom); it.fol = IDX_W'($urandom);
    it.argc = 2'($urandom);
    it.csize = ($urandom_range(15) == 0) ? FS_W'($urandom) : FS_W'($urandom_range(40));
    return it;
  endfunction

  // makes sure a source register holds a value before it is read
  task automatic fill(input logic [REG_W-1:0] r);
    instr_t it;
    if (!is_halted && !shadow_regs.exists(reg_loc(r))) begin
      it = blank(OP_LOADIMM);
      it.dst = r;
      execute(it);
    end
  endtask

  task automatic issue(input instr_t it);
    fill(it.sa);
    fill(it.sb);
    if (it.op == OP_CALL) fill(it.sc);
    execute(it);
  endtask

  task automatic issue_random();
    instr_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) it = blank(5'($urandom_range(25, 31)));
    else if (pick < 12) it = blank(OP_CALL);
    else if (pick < 20) it = blank(OP_RETURN);
    else if (pick < 30) it = blank(OP_LOADIMM);
    else begin
      it = blank(5'($urandom_range(OP_MOVE, OP_PUTCHAR)));
      if (it.op == OP_CALL && depth > 12) it.op = OP_RETURN;
    end
    issue(it);
  endtask

  task automatic wait_idle();
    while (pending_instrs.size() != 0 || expected_outcomes.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_frame_size(input logic [FS_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (depth == 0) cur_size = v;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    wait_idle();
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) issue_random();
  endtask

  // stimulus sequence
  initial begin
    instr_t it;
    wait (rst_ni);
    @(posedge clk_i);

    // directed: operand extremes and every operation except exit
    it = blank(OP_LOADIMM); it.dst = 1; it.imm = 64'h7fff_ffff_ffff_ffff; execute(it);
    it = blank(OP_LOADIMM); it.dst = 2; it.imm = 64'h8000_0000_0000_0000; execute(it);
    it = blank(OP_LOADIMM); it.dst = 3; it.imm = '1; execute(it);
    it = blank(OP_LOADIMM); it.dst = 4; it.imm = 64'd0; execute(it);
    it = blank(OP_LOADIMM); it.dst = 5; it.imm = 64'd3; execute(it);
    it = blank(OP_ADD); it.dst = 6; it.sa = 1; it.sb = 5; issue(it);
    it = blank(OP_DIV); it.dst = 7; it.sa = 2; it.sb = 3; issue(it);
    it = blank(OP_MOD); it.dst = 8; it.sa = 2; it.sb = 3; issue(it);
    it = blank(OP_DIV); it.dst = 9; it.sa = 1; it.sb = 4; issue(it);
    it = blank(OP_MODI); it.dst = 9; it.sa = 1; it.imm = 0; issue(it);
    it = blank(OP_DIVI); it.dst = 10; it.sa = 2; it.imm = -64'sd7; issue(it);
    it = blank(OP_POW); it.dst = 11; it.sa = 5; it.sb = 3; issue(it);
    it = blank(OP_BEQI); it.sa = 3; it.imm = '1; issue(it);
    it = blank(OP_BLTEI); it.sa = 5; it.imm = 64'd3; issue(it);
    it = blank(OP_BLTI); it.sa = 2; it.imm = 64'h8000_0000_0000_0000; issue(it);
    it = blank(OP_BB); it.sa = 4; issue(it);
    it = blank(OP_PUTCHAR); it.sa = 1; issue(it);
    it = blank(5'd31); issue(it);
    it = blank(OP_RETURN); issue(it);
    it = blank(OP_CALL); it.argc = 3; it.csize = 16; issue(it);
    it = blank(OP_RETURN); it.sa = 2; issue(it);
    for (int o = OP_MOVE; o <= OP_PUTCHAR; o++) issue(blank(5'(o)));

    // random phases across idle patterns and frame sizes
    run_phase(250, 0, 0);
    write_frame_size(16'd0);
    run_phase(250, 65, 0);
    write_frame_size(16'hffff);
    run_phase(250, 0, 65);
    write_frame_size(16'd37);
    run_phase(250, 16, 16);

    // window overflow at the top of the store
    while (depth > 0) issue(blank(OP_RETURN));
    write_frame_size(16'hffff);
    it = blank(OP_CALL); it.csize = 2; issue(it);
    it = blank(OP_CALL); it.csize = 1; issue(it);
    it = blank(OP_CALL); it.csize = 0; issue(it);
    it = blank(OP_RETURN); issue(it);
    write_frame_size(16'd256);

    // long receiver hold-off while the sender keeps offering
    wait_idle();
    stall_pct = 0;
    @(negedge clk_i);
    hold_left = 400;
    run_phase(200, 0, 0);

    // exit, then ignored items
    wait_idle();
    it = blank(OP_EXIT); execute(it);
    for (int i = 0; i < 6; i++) execute(blank(5'($urandom_range(31))));

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("register_window_bytecode_core regression: pass");
    end else begin
      $display("register_window_bytecode_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: register_window_bytecode_core.f
sv/rwbc_pkg.sv
sv/rwbc_mdu.sv
sv/rwbc_front.sv
sv/rwbc_back.sv
sv/register_window_bytecode_core.sv
tb/sv/testbench.sv
